// ----- sv/sdt_pkg.sv -----
// shared types, constants and a helper function for the s-box difference table row block
package sdt_pkg;

    localparam int NIB_W      = 4;
    localparam int CNT_W      = 5;
    localparam int NUM_COLS   = 16;
    localparam int SBOX_W     = 64;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int IN_PAD_W   = IN_TDATA_W - NIB_W;
    localparam int OUT_PAD_W  = OUT_TDATA_W - NIB_W - CNT_W;

    localparam logic [SBOX_W-1:0] SBOX_RESET = 64'hFEDCBA9876543210;
    localparam logic [NIB_W-1:0]  LAST_COL   = 4'd15;

    // one output difference per s-box input x
    typedef logic [NUM_COLS-1:0][NIB_W-1:0] diff_vec_t;
    // match[col][x]: output difference of x equals col
    typedef logic [NUM_COLS-1:0][NUM_COLS-1:0] match_mat_t;
    // one count per output difference
    typedef logic [NUM_COLS-1:0][CNT_W-1:0] count_vec_t;

    function automatic logic [NIB_W-1:0] sbox_apply(input logic [SBOX_W-1:0] sbox,
                                                    input logic [NIB_W-1:0] x);
        return sbox[{x, 2'b00} +: NIB_W];
    endfunction

endpackage

// ----- sv/sdt_lanes.sv -----
// stage one: sixteen lanes forming s(x) xor s(x xor a) for every x
module sdt_lanes (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [sdt_pkg::SBOX_W-1:0] sbox,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [sdt_pkg::NIB_W-1:0] in_diff,
    output logic                      out_valid,
    input  logic                      out_ready,
    output sdt_pkg::diff_vec_t        out_diffs
);

    logic               valid_reg;
    logic               valid_next;
    sdt_pkg::diff_vec_t diffs_reg;
    sdt_pkg::diff_vec_t diffs_next;
    logic               load;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        for (int x = 0; x < sdt_pkg::NUM_COLS; x++)
        begin
            diffs_next[x] = sdt_pkg::sbox_apply(sbox, sdt_pkg::NIB_W'(x))
                          ^ sdt_pkg::sbox_apply(sbox, sdt_pkg::NIB_W'(x) ^ in_diff);
        end
    end

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            diffs_reg <= diffs_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_diffs = diffs_reg;

endmodule

// ----- sv/sdt_count.sv -----
// stages two and three: column match matrix, then per-column population counts
module sdt_count (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  sdt_pkg::diff_vec_t  in_diffs,
    output logic                out_valid,
    input  logic                out_ready,
    output sdt_pkg::count_vec_t out_counts
);

    logic                match_v_reg;
    logic                match_v_next;
    sdt_pkg::match_mat_t match_reg;
    sdt_pkg::match_mat_t match_next;
    logic                match_ready;
    logic                match_load;

    logic                cnt_v_reg;
    logic                cnt_v_next;
    sdt_pkg::count_vec_t counts_reg;
    sdt_pkg::count_vec_t counts_next;
    logic                cnt_load;

    assign match_ready = !cnt_v_reg || out_ready;
    assign in_ready    = !match_v_reg || match_ready;
    assign match_load  = in_valid && in_ready;
    assign cnt_load    = match_v_reg && match_ready;

    always_comb
    begin
        for (int c = 0; c < sdt_pkg::NUM_COLS; c++)
        begin
            for (int x = 0; x < sdt_pkg::NUM_COLS; x++)
            begin
                match_next[c][x] = (in_diffs[x] == sdt_pkg::NIB_W'(c));
            end
        end
    end

    // two-level adder tree: four groups of four bits, then the group sums
    always_comb
    begin
        logic [3:0][2:0] part;
        part = '0;
        for (int c = 0; c < sdt_pkg::NUM_COLS; c++)
        begin
            for (int g = 0; g < 4; g++)
            begin
                part[g] = 3'(match_reg[c][4*g])   + 3'(match_reg[c][4*g+1])
                        + 3'(match_reg[c][4*g+2]) + 3'(match_reg[c][4*g+3]);
            end
            counts_next[c] = sdt_pkg::CNT_W'(part[0]) + sdt_pkg::CNT_W'(part[1])
                           + sdt_pkg::CNT_W'(part[2]) + sdt_pkg::CNT_W'(part[3]);
        end
    end

    always_comb
    begin
        if (match_load)
        begin
            match_v_next = 1'b1;
        end
        else if (match_ready)
        begin
            match_v_next = 1'b0;
        end
        else
        begin
            match_v_next = match_v_reg;
        end

        if (cnt_load)
        begin
            cnt_v_next = 1'b1;
        end
        else if (out_ready)
        begin
            cnt_v_next = 1'b0;
        end
        else
        begin
            cnt_v_next = cnt_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_v_reg <= 1'b0;
            cnt_v_reg   <= 1'b0;
        end
        else
        begin
            match_v_reg <= match_v_next;
            cnt_v_reg   <= cnt_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (match_load)
        begin
            match_reg <= match_next;
        end
        if (cnt_load)
        begin
            counts_reg <= counts_next;
        end
    end

    assign out_valid  = cnt_v_reg;
    assign out_counts = counts_reg;

endmodule

// ----- sv/sdt_serial.sv -----
// output stage: shifts the sixteen column counts out one word per beat
module sdt_serial (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  sdt_pkg::count_vec_t       in_counts,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [sdt_pkg::NIB_W-1:0] out_col,
    output logic [sdt_pkg::CNT_W-1:0] out_count,
    output logic                      out_last
);

    logic                      busy_reg;
    logic                      busy_next;
    logic [sdt_pkg::NIB_W-1:0] col_reg;
    logic [sdt_pkg::NIB_W-1:0] col_next;
    sdt_pkg::count_vec_t       counts_reg;
    sdt_pkg::count_vec_t       counts_next;
    logic                      beat;
    logic                      done;
    logic                      load;

    assign beat     = busy_reg && out_ready;
    assign done     = beat && (col_reg == sdt_pkg::LAST_COL);
    assign in_ready = !busy_reg || done;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        busy_next   = busy_reg;
        col_next    = col_reg;
        counts_next = counts_reg;
        if (load)
        begin
            busy_next   = 1'b1;
            col_next    = '0;
            counts_next = in_counts;
        end
        else if (beat)
        begin
            busy_next = !done;
            col_next  = col_reg + 1'b1;
            for (int i = 0; i < sdt_pkg::NUM_COLS - 1; i++)
            begin
                counts_next[i] = counts_reg[i+1];
            end
            counts_next[sdt_pkg::NUM_COLS-1] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            col_reg  <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        counts_reg <= counts_next;
    end

    assign out_valid = busy_reg;
    assign out_col   = col_reg;
    assign out_count = counts_reg[0];
    assign out_last  = (col_reg == sdt_pkg::LAST_COL);

`ifndef SYNTHESIS
    a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_ready && col_reg != sdt_pkg::LAST_COL
        |=> busy_reg && col_reg == sdt_pkg::NIB_W'($past(col_reg) + 1'b1))
        else $error("column did not advance after a taken word");

    a_row_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> busy_reg && col_reg == '0)
        else $error("new row did not start at column zero");

    a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && out_ready && col_reg == sdt_pkg::LAST_COL && !in_valid |=> !busy_reg)
        else $error("serializer stayed busy after the last word");
`endif

endmodule

// ----- sv/sbox_difference_table_row_core.sv -----
// top level: difference distribution table row of a configurable 4-bit s-box
//
//  channel   dir  handshake                    contents
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata[3:0] input_difference
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata[3:0] output_difference,
//                                              tdata[8:4] pair_count, tlast last_of_row
//  cfg       in   cfg_wr_en                    cfg_wr_data[63:0] sbox_entries
//
//  an input word passes three register stages (difference lanes, match matrix,
//  column counts) and then the output shifter register before its first result is presented
//  sixteen result words per input word, one per cycle when m_axis_tready holds;
//  the output shifter limits the sustained rate, taking a new row only as its last word is taken
//  reset clears all valid bits and the column counter and loads the identity s-box
//  stalls back up stage by stage through the ready chain without losing any word
module sbox_difference_table_row_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [sdt_pkg::SBOX_W-1:0]          cfg_wr_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sdt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [3:0] input_difference
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sdt_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [3:0] output_difference, [8:4] pair_count
    output logic                                m_axis_tlast    // last_of_row
);

    logic [sdt_pkg::SBOX_W-1:0] sbox_reg;
    logic                       lanes_valid;
    logic                       lanes_ready;
    sdt_pkg::diff_vec_t         lanes_diffs;
    logic                       cnt_valid;
    logic                       cnt_ready;
    sdt_pkg::count_vec_t        cnt_counts;
    logic [sdt_pkg::NIB_W-1:0]  out_col;
    logic [sdt_pkg::CNT_W-1:0]  out_count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sbox_reg <= sdt_pkg::SBOX_RESET;
        end
        else if (cfg_wr_en)
        begin
            sbox_reg <= cfg_wr_data;
        end
    end

    sdt_lanes u_lanes (
        .clk       (clk),
        .rst_n     (rst_n),
        .sbox      (sbox_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_diff   (s_axis_tdata[sdt_pkg::NIB_W-1:0]),
        .out_valid (lanes_valid),
        .out_ready (lanes_ready),
        .out_diffs (lanes_diffs)
    );

    sdt_count u_count (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (lanes_valid),
        .in_ready   (lanes_ready),
        .in_diffs   (lanes_diffs),
        .out_valid  (cnt_valid),
        .out_ready  (cnt_ready),
        .out_counts (cnt_counts)
    );

    sdt_serial u_serial (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cnt_valid),
        .in_ready  (cnt_ready),
        .in_counts (cnt_counts),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_col   (out_col),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{sdt_pkg::OUT_PAD_W{1'b0}}, out_count, out_col};

endmodule

// ----- test/tb.sv -----
// testbench for the s-box difference table row core: directed rows, then randomized phases
`timescale 1ns / 100ps

module tb;

    localparam int HALF_PERIOD   = 2;
    localparam int RESET_CYCLES  = 9;
    localparam int WATCHDOG_MAX  = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEMS_PER_PHASE = 22;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [sdt_pkg::NIB_W-1:0] odiff;
        logic [sdt_pkg::CNT_W-1:0] count;
        logic                      last;
    } row_word_t;

    typedef struct packed {
        logic                       wr;
        logic [sdt_pkg::SBOX_W-1:0] sbox;
        logic [sdt_pkg::NIB_W-1:0]  diff;
        logic                       hot_known;
        logic [sdt_pkg::NIB_W-1:0]  hot_col;
    } dir_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [sdt_pkg::SBOX_W-1:0]      cfg_wr_data = '0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [sdt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [sdt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    logic [sdt_pkg::SBOX_W-1:0] sbox_model = sdt_pkg::SBOX_RESET;
    row_word_t                  expected_words[$];
    dir_row_t                   dir_tab[$];
    row_word_t                  want;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int err_cnt = 0;
    int words_sent = 0;
    int words_checked = 0;
    int sbox_writes = 0;
    int quiet_cycles = 0;

    sbox_difference_table_row_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #HALF_PERIOD clk = ~clk;

    // count pairs per output difference under the current s-box
    function automatic void push_ddt_row(input logic [sdt_pkg::NIB_W-1:0] diff);
        int                        cnt[sdt_pkg::NUM_COLS];
        logic [sdt_pkg::NIB_W-1:0] x;
        logic [sdt_pkg::NIB_W-1:0] d;
        row_word_t                 w;
        for (int c = 0; c < sdt_pkg::NUM_COLS; c++)
            cnt[c] = 0;
        for (int i = 0; i < sdt_pkg::NUM_COLS; i++)
        begin
            x = i[sdt_pkg::NIB_W-1:0];
            d = sbox_model[{x, 2'b00} +: sdt_pkg::NIB_W]
              ^ sbox_model[{x ^ diff, 2'b00} +: sdt_pkg::NIB_W];
            cnt[d]++;
        end
        for (int c = 0; c < sdt_pkg::NUM_COLS; c++)
        begin
            w.odiff = c[sdt_pkg::NIB_W-1:0];
            w.count = cnt[c][sdt_pkg::CNT_W-1:0];
            w.last  = (w.odiff == sdt_pkg::LAST_COL);
            expected_words.push_back(w);
        end
    endfunction

    // row where one column takes all sixteen pairs
    function automatic void push_hot_row(input logic [sdt_pkg::NIB_W-1:0] hot);
        row_word_t w;
        for (int c = 0; c < sdt_pkg::NUM_COLS; c++)
        begin
            w.odiff = c[sdt_pkg::NIB_W-1:0];
            w.count = (w.odiff == hot) ? 5'd16 : 5'd0;
            w.last  = (w.odiff == sdt_pkg::LAST_COL);
            expected_words.push_back(w);
        end
    endfunction

    function automatic logic [sdt_pkg::SBOX_W-1:0] random_perm_sbox();
        int p[sdt_pkg::NUM_COLS];
        int j;
        int t;
        logic [sdt_pkg::SBOX_W-1:0] v;
        for (int i = 0; i < sdt_pkg::NUM_COLS; i++)
            p[i] = i;
        for (int i = sdt_pkg::NUM_COLS - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            t = p[i];
            p[i] = p[j];
            p[j] = t;
        end
        for (int i = 0; i < sdt_pkg::NUM_COLS; i++)
            v[4*i +: sdt_pkg::NIB_W] = p[i][sdt_pkg::NIB_W-1:0];
        return v;
    endfunction

    function automatic dir_row_t dir_row(input logic wr,
                                         input logic [sdt_pkg::SBOX_W-1:0] sbox,
                                         input logic [sdt_pkg::NIB_W-1:0] diff,
                                         input logic hot_known,
                                         input logic [sdt_pkg::NIB_W-1:0] hot_col);
        dir_row_t r;
        r.wr = wr;
        r.sbox = sbox;
        r.diff = diff;
        r.hot_known = hot_known;
        r.hot_col = hot_col;
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
            $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // called at a falling edge; returns at a falling edge with the block idle
    task automatic drain_results();
        s_axis_tvalid = 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_sbox(input logic [sdt_pkg::SBOX_W-1:0] value);
        drain_results();
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        sbox_model = value;
        sbox_writes++;
    endtask

    // called at a falling edge; leaves tvalid high so back-to-back words need no gap
    task automatic send_word(input logic [sdt_pkg::NIB_W-1:0] diff, input logic hot_known,
                             input logic [sdt_pkg::NIB_W-1:0] hot_col);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {{sdt_pkg::IN_PAD_W{1'b0}}, diff};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (hot_known)
            push_hot_row(hot_col);
        else
            push_ddt_row(diff);
        words_sent++;
        @(negedge clk);
    endtask

    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_checked++;
            if (expected_words.size() == 0)
                note_mismatch($sformatf("unexpected word tdata=%h tlast=%b",
                                        m_axis_tdata, m_axis_tlast));
            else
            begin
                want = expected_words.pop_front();
                if (m_axis_tdata[sdt_pkg::NIB_W-1:0] !== want.odiff
                    || m_axis_tdata[sdt_pkg::NIB_W +: sdt_pkg::CNT_W] !== want.count
                    || m_axis_tdata[sdt_pkg::OUT_TDATA_W-1:sdt_pkg::NIB_W+sdt_pkg::CNT_W]
                       !== {sdt_pkg::OUT_PAD_W{1'b0}}
                    || m_axis_tlast !== want.last)
                    note_mismatch($sformatf(
                        "col exp %0d got %0d, count exp %0d got %0d, last exp %b got %b, pad %h",
                        want.odiff, m_axis_tdata[sdt_pkg::NIB_W-1:0], want.count,
                        m_axis_tdata[sdt_pkg::NIB_W +: sdt_pkg::CNT_W], want.last, m_axis_tlast,
                        m_axis_tdata[sdt_pkg::OUT_TDATA_W-1:sdt_pkg::NIB_W+sdt_pkg::CNT_W]));
            end
        end
    end

    // watchdog on cycles where neither channel moves a word
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_MAX)
        begin
            $display("watchdog expired with %0d words outstanding", expected_words.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        // identity after reset: the difference itself takes every pair
        dir_tab.push_back(dir_row(1'b0, sdt_pkg::SBOX_RESET, 4'd0, 1'b1, 4'd0));
        dir_tab.push_back(dir_row(1'b0, sdt_pkg::SBOX_RESET, 4'd15, 1'b1, 4'd15));
        dir_tab.push_back(dir_row(1'b0, sdt_pkg::SBOX_RESET, 4'd1, 1'b1, 4'd1));
        dir_tab.push_back(dir_row(1'b0, sdt_pkg::SBOX_RESET, 4'd8, 1'b1, 4'd8));
        dir_tab.push_back(dir_row(1'b0, sdt_pkg::SBOX_RESET, 4'd6, 1'b1, 4'd6));
        // constant s-boxes: everything lands in column 0
        dir_tab.push_back(dir_row(1'b1, 64'h0, 4'd0, 1'b1, 4'd0));
        dir_tab.push_back(dir_row(1'b0, 64'h0, 4'd15, 1'b1, 4'd0));
        dir_tab.push_back(dir_row(1'b0, 64'h0, 4'd9, 1'b1, 4'd0));
        dir_tab.push_back(dir_row(1'b1, {sdt_pkg::SBOX_W{1'b1}}, 4'd7, 1'b1, 4'd0));
        dir_tab.push_back(dir_row(1'b0, {sdt_pkg::SBOX_W{1'b1}}, 4'd0, 1'b1, 4'd0));
        // a well-known 4-bit cipher s-box
        dir_tab.push_back(dir_row(1'b1, 64'h21748FE3DA09B65C, 4'd0, 1'b1, 4'd0));
        dir_tab.push_back(dir_row(1'b0, 64'h21748FE3DA09B65C, 4'd1, 1'b0, 4'd0));
        dir_tab.push_back(dir_row(1'b0, 64'h21748FE3DA09B65C, 4'd15, 1'b0, 4'd0));
        dir_tab.push_back(dir_row(1'b0, 64'h21748FE3DA09B65C, 4'd6, 1'b0, 4'd0));
        dir_tab.push_back(dir_row(1'b0, 64'h21748FE3DA09B65C, 4'd10, 1'b0, 4'd0));
        // non-bijective: 15 for the low half, 0 for the high half
        dir_tab.push_back(dir_row(1'b1, 64'h00000000FFFFFFFF, 4'd8, 1'b1, 4'd15));
        dir_tab.push_back(dir_row(1'b0, 64'h00000000FFFFFFFF, 4'd3, 1'b1, 4'd0));
        dir_tab.push_back(dir_row(1'b0, 64'h00000000FFFFFFFF, 4'd12, 1'b0, 4'd0));
        dir_tab.push_back(dir_row(1'b1, 64'hA5A55A5A3C3CC3C3, 4'd5, 1'b0, 4'd0));
        dir_tab.push_back(dir_row(1'b0, 64'hA5A55A5A3C3CC3C3, 4'd14, 1'b0, 4'd0));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].wr)
                write_sbox(dir_tab[i].sbox);
            send_word(dir_tab[i].diff, dir_tab[i].hot_known, dir_tab[i].hot_col);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    send_idle_pct = 17;
                    stall_pct = 17;
                end
            endcase
            write_sbox((ph % 2 == 0) ? random_perm_sbox() : {$urandom, $urandom});
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                // hold the sender off until the block has emptied
                if (ph == 1 && k == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_word(sdt_pkg::NIB_W'($urandom_range(15)), 1'b0, 4'd0);
            end
        end

        drain_results();
        repeat (2 * sdt_pkg::NUM_COLS) @(negedge clk);

        $display("sent %0d difference words under %0d s-box settings, checked %0d table words",
                 words_sent, sbox_writes + 1, words_checked);
        $display("phases: back-to-back, sender gaps, receiver stalls, both; %0d mismatches",
                 err_cnt);
        if (err_cnt == 0 && expected_words.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
